### rtl/swc_pkg.sv
// ----------------------------------------------------------------------------
// swc_pkg
// Shared types, widths and codes of the swipe direction classifier.
// ----------------------------------------------------------------------------
package swc_pkg;

  localparam int unsigned MAX_POINTS = 1023;
  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned THR_W      = 8;
  localparam int unsigned CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int unsigned S_W        = CNT_W + 1;
  localparam int unsigned CMP_W      = CNT_W + THR_W;
  localparam int unsigned NUM_DIR    = 4;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // register index (byte address / 4)
  localparam logic [APB_ADDR_W-3:0] REG_THRESHOLD = '0;
  localparam logic [THR_W-1:0]      THRESHOLD_RESET = THR_W'(179);

  // direction slots
  localparam int unsigned DIR_RIGHT = 0;
  localparam int unsigned DIR_LEFT  = 1;
  localparam int unsigned DIR_TOP   = 2;
  localparam int unsigned DIR_ABOVE = 3;

  typedef enum logic [3:0] {
    GEST_NONE        = 4'd0,
    GEST_RIGHT       = 4'd1,
    GEST_LEFT        = 4'd2,
    GEST_TOP         = 4'd3,
    GEST_ABOVE       = 4'd4,
    GEST_RIGHT_TOP   = 4'd5,
    GEST_LEFT_TOP    = 4'd6,
    GEST_RIGHT_ABOVE = 4'd7,
    GEST_LEFT_ABOVE  = 4'd8
  } gesture_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  last_point;
  } in_t;

  typedef struct packed {
    logic [3:0] gesture_code;
    logic       length_overflow;
  } out_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } pt_t;

  // everything the decision stage needs about one finished path
  typedef struct packed {
    logic [NUM_DIR-1:0][S_W-1:0] score;
    logic [CNT_W-1:0]            n;
    logic [COORD_BITS-1:0]       adx;
    logic [COORD_BITS-1:0]       ady;
    logic                        dx_pos;
    logic                        dy_pos;
    logic                        ovf;
  } score_t;

endpackage

### rtl/swipe_direction_classifier.sv
// ----------------------------------------------------------------------------
// swipe_direction_classifier
// Classifies one fingertip path, fed point by point, as a swipe direction.
// ----------------------------------------------------------------------------
// Input channel: one point per transaction (in_valid_i / in_stall_o); the
// point flagged last_point closes the path. Only that point produces a
// result transaction on the output channel (out_valid_o / out_stall_i)
// carrying gesture_code and length_overflow; other points produce none.
// Pipeline: three register stages (input register, path state / score
// register, result register). The input register loads at the accepting
// edge; a result then passes the score register and the result register.
// Throughput: one point per cycle while the receiver does not stall, set by
// the path state update.
// When the receiver stalls, the result register holds its transaction and
// the stages behind it keep filling until each one holds an item; then
// in_stall_o rises. The threshold register sits on an APB-style port at byte
// address 0 and should be written only while no path is in flight.
// Reset clears all path state and loads the threshold with 179.
// ----------------------------------------------------------------------------
module swipe_direction_classifier import swc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic             in_valid_q, in_valid_d;
  in_t              in_data_q;
  logic             in_ready;
  logic             pt_ready;
  logic             score_valid;
  score_t           score;
  logic             score_ready;
  logic [THR_W-1:0] thr_q;
  logic             reg_sel;

  // ---- configuration ----
  assign pready  = 1'b1;
  assign reg_sel = paddr[APB_ADDR_W-1:2] == REG_THRESHOLD;
  assign prdata  = reg_sel ? APB_DATA_W'(thr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      thr_q <= pwdata[THR_W-1:0];
    end
  end

  // ---- input register ----
  assign in_ready    = !in_valid_q || pt_ready;
  assign in_stall_o  = !in_ready;
  assign in_valid_d  = (in_valid_i && in_ready) || (in_valid_q && !pt_ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready) begin
      in_data_q <= in_data_i;
    end
  end

  swc_path_tracker u_tracker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pt_valid_i    (in_valid_q),
    .pt_data_i     (in_data_q),
    .pt_ready_o    (pt_ready),
    .score_valid_o (score_valid),
    .score_o       (score),
    .score_ready_i (score_ready)
  );

  swc_decide u_decide (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .threshold_i   (thr_q),
    .score_valid_i (score_valid),
    .score_i       (score),
    .score_ready_o (score_ready),
    .out_valid_o   (out_valid_o),
    .out_data_o    (out_data_o),
    .out_stall_i   (out_stall_i)
  );

endmodule

### rtl/swc_path_tracker.sv
// ----------------------------------------------------------------------------
// swc_path_tracker
// Per-point path state update; on the last point, builds the direction
// scores and displacements into the score register and clears the path.
// ----------------------------------------------------------------------------
module swc_path_tracker import swc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   pt_valid_i,
  input  in_t    pt_data_i,
  output logic   pt_ready_o,
  output logic   score_valid_o,
  output score_t score_o,
  input  logic   score_ready_i
);

  pt_t                           first_q, first_d;
  pt_t                           hist0_q, hist0_d;
  pt_t                           hist1_q, hist1_d;
  logic [NUM_DIR-1:0][CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0]              n_q, n_d;
  logic                          ovf_q, ovf_d;
  logic                          score_valid_q, score_valid_d;
  score_t                        score_q, score_d;

  pt_t  p;
  logic take;
  logic fx_gt, fx_lt, fy_gt, fy_lt;

  assign pt_ready_o = !score_valid_q || score_ready_i;
  assign take       = pt_valid_i && pt_ready_o;
  assign p.x        = pt_data_i.point_x;
  assign p.y        = pt_data_i.point_y;

  always_comb begin
    first_d = first_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    ovf_d   = ovf_q;
    if (n_q == CNT_W'(MAX_POINTS)) begin
      ovf_d = 1'b1;
    end else begin
      if (n_q == '0) begin
        first_d = p;
      end
      if (n_q >= CNT_W'(2)) begin
        if (hist1_q.x >= p.x) cnt_d[DIR_RIGHT] = cnt_q[DIR_RIGHT] + 1'b1;
        if (hist1_q.x <= p.x) cnt_d[DIR_LEFT]  = cnt_q[DIR_LEFT] + 1'b1;
        if (hist1_q.y >= p.y) cnt_d[DIR_TOP]   = cnt_q[DIR_TOP] + 1'b1;
        if (hist1_q.y <= p.y) cnt_d[DIR_ABOVE] = cnt_q[DIR_ABOVE] + 1'b1;
      end
      n_d = n_q + 1'b1;
    end
    hist1_d = hist0_q;
    hist0_d = p;
  end

  assign fx_gt = first_d.x > p.x;
  assign fx_lt = first_d.x < p.x;
  assign fy_gt = first_d.y > p.y;
  assign fy_lt = first_d.y < p.y;

  always_comb begin
    score_d.score[DIR_RIGHT] = S_W'(cnt_d[DIR_RIGHT]) + (fx_gt ? S_W'(n_d) : '0);
    score_d.score[DIR_LEFT]  = S_W'(cnt_d[DIR_LEFT])  + (fx_lt ? S_W'(n_d) : '0);
    score_d.score[DIR_TOP]   = S_W'(cnt_d[DIR_TOP])   + (fy_gt ? S_W'(n_d) : '0);
    score_d.score[DIR_ABOVE] = S_W'(cnt_d[DIR_ABOVE]) + (fy_lt ? S_W'(n_d) : '0);
    score_d.n      = n_d;
    score_d.adx    = fx_gt ? first_d.x - p.x : p.x - first_d.x;
    score_d.ady    = fy_gt ? first_d.y - p.y : p.y - first_d.y;
    score_d.dx_pos = fx_gt;
    score_d.dy_pos = fy_gt;
    score_d.ovf    = ovf_d;
  end

  assign score_valid_d = take ? pt_data_i.last_point
                              : (score_valid_q && !score_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q       <= '0;
      hist0_q       <= '0;
      hist1_q       <= '0;
      cnt_q         <= '0;
      n_q           <= '0;
      ovf_q         <= 1'b0;
      score_valid_q <= 1'b0;
    end else begin
      score_valid_q <= score_valid_d;
      if (take) begin
        if (pt_data_i.last_point) begin
          // path done: back to the empty-path state
          first_q <= '0;
          hist0_q <= '0;
          hist1_q <= '0;
          cnt_q   <= '0;
          n_q     <= '0;
          ovf_q   <= 1'b0;
        end else begin
          first_q <= first_d;
          hist0_q <= hist0_d;
          hist1_q <= hist1_d;
          cnt_q   <= cnt_d;
          n_q     <= n_d;
          ovf_q   <= ovf_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && pt_data_i.last_point) begin
      score_q <= score_d;
    end
  end

  assign score_valid_o = score_valid_q;
  assign score_o       = score_q;

endmodule

### rtl/swc_decide.sv
// ----------------------------------------------------------------------------
// swc_decide
// Threshold tests, best single direction and diagonal overrides; drives the
// result register.
// ----------------------------------------------------------------------------
module swc_decide import swc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [THR_W-1:0] threshold_i,
  input  logic             score_valid_i,
  input  score_t           score_i,
  output logic             score_ready_o,
  output logic             out_valid_o,
  output out_t             out_data_o,
  input  logic             out_stall_i
);

  logic                  out_valid_q, out_valid_d;
  out_t                  out_data_q, out_data_d;
  logic [CMP_W-1:0]      tn;
  logic [S_W-1:0]        mx01, mx23, mx;
  logic [NUM_DIR-1:0]    pass;
  logic                  ratio_ok, same_sign;
  logic [S_W:0]          sum_rt, sum_lt, sum_ra, sum_la;
  logic                  take;
  gesture_e              code;

  assign score_ready_o = !out_valid_q || !out_stall_i;
  assign take          = score_valid_i && score_ready_o;

  assign tn = CMP_W'(threshold_i) * CMP_W'(score_i.n);

  assign mx01 = (score_i.score[1] > score_i.score[0]) ? score_i.score[1] : score_i.score[0];
  assign mx23 = (score_i.score[3] > score_i.score[2]) ? score_i.score[3] : score_i.score[2];
  assign mx   = (mx23 > mx01) ? mx23 : mx01;

  always_comb begin
    for (int i = 0; i < NUM_DIR; i++) begin
      pass[i] = (score_i.score[i] == mx) && ({score_i.score[i], 7'b0} > tn);
    end
  end

  // displacement ratio strictly inside (0.5, 2), zero fails
  assign ratio_ok  = (score_i.adx != '0) && (score_i.ady != '0) &&
                     ({score_i.adx, 1'b0} > {1'b0, score_i.ady}) &&
                     ({1'b0, score_i.adx} < {score_i.ady, 1'b0});
  assign same_sign = score_i.dx_pos == score_i.dy_pos;

  assign sum_rt = {1'b0, score_i.score[DIR_RIGHT]} + {1'b0, score_i.score[DIR_TOP]};
  assign sum_lt = {1'b0, score_i.score[DIR_LEFT]}  + {1'b0, score_i.score[DIR_TOP]};
  assign sum_ra = {1'b0, score_i.score[DIR_RIGHT]} + {1'b0, score_i.score[DIR_ABOVE]};
  assign sum_la = {1'b0, score_i.score[DIR_LEFT]}  + {1'b0, score_i.score[DIR_ABOVE]};

  always_comb begin
    code = GEST_NONE;
    if (pass[DIR_RIGHT]) code = GEST_RIGHT;
    if (pass[DIR_LEFT])  code = GEST_LEFT;
    if (pass[DIR_TOP])   code = GEST_TOP;
    if (pass[DIR_ABOVE]) code = GEST_ABOVE;
    // right/left displacements are negatives of each other, as are top/above
    if (ratio_ok && same_sign && ({sum_rt, 6'b0} > tn))  code = GEST_RIGHT_TOP;
    if (ratio_ok && !same_sign && ({sum_lt, 6'b0} > tn)) code = GEST_LEFT_TOP;
    if (ratio_ok && !same_sign && ({sum_ra, 6'b0} > tn)) code = GEST_RIGHT_ABOVE;
    if (ratio_ok && same_sign && ({sum_la, 6'b0} > tn))  code = GEST_LEFT_ABOVE;
  end

  always_comb begin
    out_data_d.gesture_code    = code;
    out_data_d.length_overflow = score_i.ovf;
  end

  assign out_valid_d = take ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### tb/sv/tb_swipe_direction_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_swipe_direction_classifier
// Self-checking bench: feeds fingertip paths point by point over a
// valid/stall channel under random bursts, receiver stalls and one long
// receiver hold. It predicts each gesture and overflow flag from its own
// path tracker and checks every result transaction in order. The threshold
// is reprogrammed over APB between phases, including 0 and 255.
// ----------------------------------------------------------------------------

import swc_pkg::*;

class gesture_tracker;
  logic [THR_W-1:0] thr;
  pt_t              first_pt;
  pt_t              hist[2];
  logic [CNT_W-1:0] dir_cnt[NUM_DIR];
  logic [CNT_W-1:0] n_pts;
  bit               ovf;
  out_t             pending_gestures[$];
  int unsigned      errors;
  int unsigned      checked;
  int unsigned      ovf_paths;

  function new();
    thr = THRESHOLD_RESET;
    clear_path();
  endfunction

  function void clear_path();
    first_pt = '0;
    hist[0]  = '0;
    hist[1]  = '0;
    foreach (dir_cnt[i]) dir_cnt[i] = '0;
    n_pts = '0;
    ovf   = 1'b0;
  endfunction

  function int pending();
    return pending_gestures.size();
  endfunction

  task report_mismatch(string what);
    errors++;
    if (errors <= 20) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // both displacements point the same way and da/db lies strictly in (0.5, 2)
  function bit ratio_inside(int da, int db);
    int ma;
    int mb;
    if (da == 0 || db == 0) return 1'b0;
    if ((da > 0) != (db > 0)) return 1'b0;
    ma = (da < 0) ? -da : da;
    mb = (db < 0) ? -db : db;
    return (2 * ma > mb) && (ma < 2 * mb);
  endfunction

  function out_t classify_path(pt_t q);
    int unsigned s[NUM_DIR];
    int          d[NUM_DIR];
    int unsigned n;
    int unsigned t;
    int unsigned mx;
    int unsigned a;
    int unsigned b;
    gesture_e    g;
    out_t        r;
    n = n_pts;
    t = thr;
    s[DIR_RIGHT] = ((first_pt.x > q.x) ? n : 0) + dir_cnt[DIR_RIGHT];
    s[DIR_LEFT]  = ((first_pt.x < q.x) ? n : 0) + dir_cnt[DIR_LEFT];
    s[DIR_TOP]   = ((first_pt.y > q.y) ? n : 0) + dir_cnt[DIR_TOP];
    s[DIR_ABOVE] = ((first_pt.y < q.y) ? n : 0) + dir_cnt[DIR_ABOVE];
    d[DIR_RIGHT] = int'(first_pt.x) - int'(q.x);
    d[DIR_LEFT]  = -d[DIR_RIGHT];
    d[DIR_TOP]   = int'(first_pt.y) - int'(q.y);
    d[DIR_ABOVE] = -d[DIR_TOP];
    mx = s[0];
    for (int i = 1; i < NUM_DIR; i++) if (s[i] > mx) mx = s[i];
    g = GEST_NONE;
    // later direction wins a tie
    for (int i = 0; i < NUM_DIR; i++)
      if (s[i] == mx && s[i] * 128 > t * n) g = gesture_e'(i + 1);
    // diagonals in code order, later rule overrides
    for (int k = 0; k < 4; k++) begin
      a = (k % 2 == 0) ? DIR_RIGHT : DIR_LEFT;
      b = (k < 2) ? DIR_TOP : DIR_ABOVE;
      if ((s[a] + s[b]) * 64 > t * n && ratio_inside(d[a], d[b]))
        g = gesture_e'(GEST_RIGHT_TOP + k);
    end
    r.gesture_code    = g;
    r.length_overflow = ovf;
    return r;
  endfunction

  function void note_point(in_t item);
    pt_t  p;
    out_t r;
    p.x = item.point_x;
    p.y = item.point_y;
    if (n_pts >= MAX_POINTS) begin
      ovf = 1'b1;
    end else begin
      if (n_pts == 0) first_pt = p;
      if (n_pts >= 2) begin
        if (hist[1].x >= p.x) dir_cnt[DIR_RIGHT]++;
        if (hist[1].x <= p.x) dir_cnt[DIR_LEFT]++;
        if (hist[1].y >= p.y) dir_cnt[DIR_TOP]++;
        if (hist[1].y <= p.y) dir_cnt[DIR_ABOVE]++;
      end
      n_pts++;
    end
    hist[1] = hist[0];
    hist[0] = p;
    if (item.last_point) begin
      r = classify_path(p);
      if (r.length_overflow) ovf_paths++;
      pending_gestures.push_back(r);
      clear_path();
    end
  endfunction

  task check_gesture(out_t got);
    out_t exp_r;
    if (pending_gestures.size() == 0) begin
      report_mismatch($sformatf("result code %0d with no path waiting", got.gesture_code));
    end else begin
      exp_r = pending_gestures.pop_front();
      checked++;
      if (got.gesture_code !== exp_r.gesture_code)
        report_mismatch($sformatf("gesture_code %0d, expected %0d",
                                  got.gesture_code, exp_r.gesture_code));
      if (got.length_overflow !== exp_r.length_overflow)
        report_mismatch($sformatf("length_overflow %0b, expected %0b",
                                  got.length_overflow, exp_r.length_overflow));
    end
  endtask
endclass

module tb_swipe_direction_classifier;

  localparam int LATENCY     = 3;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_e;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_t                   in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_t                  out_data_o;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  gesture_tracker gestures = new();

  int          n_points    = 0;
  int          n_paths     = 0;
  int          burst_left  = 0;
  int          quiet_cycles = 0;
  bit          hold_armed  = 1'b0;
  int          hold_left   = 0;
  int          mode_left   = 0;
  stall_mode_e stall_mode  = STALL_NONE;

  swipe_direction_classifier DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) gestures.check_gesture(out_data_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stall modes plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_armed) begin
      hold_left  = HOLD_CYCLES;
      hold_armed = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 2));
        mode_left  = $urandom_range(10, 100);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        default:     out_stall_i <= ($urandom_range(0, 2) != 0);
      endcase
    end
  end

  function automatic logic [COORD_BITS-1:0] coord_clamp(int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return '1;
    return v[COORD_BITS-1:0];
  endfunction

  task automatic send_point(in_t item);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    gestures.note_point(item);
    n_points++;
    burst_left--;
  endtask

  // straight line from (x0, y0) with per-point step and optional jitter
  task automatic send_path(int x0, int y0, int dx, int dy, int len, int jit);
    in_t item;
    int  jx;
    int  jy;
    for (int i = 0; i < len; i++) begin
      jx = int'($urandom_range(0, 2 * jit)) - jit;
      jy = int'($urandom_range(0, 2 * jit)) - jit;
      item.point_x    = coord_clamp(x0 + i * dx + jx);
      item.point_y    = coord_clamp(y0 + i * dy + jy);
      item.last_point = (i == len - 1);
      send_point(item);
    end
    n_paths++;
  endtask

  task automatic random_path();
    int len;
    int x0;
    int y0;
    int dx;
    int dy;
    int jit;
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
    x0  = $urandom_range(0, COORD_MAX);
    y0  = $urandom_range(0, COORD_MAX);
    if ($urandom_range(0, 9) == 0) begin
      send_path(x0, y0, 0, 0, len, 2048);
    end else begin
      dx = ($urandom_range(0, 4) == 0) ? 0 : int'($urandom_range(0, 80)) - 40;
      case ($urandom_range(0, 3))
        0:       dy = 0;
        1:       dy = 2 * dx;
        2:       dy = dx / 2;
        default: dy = int'($urandom_range(0, 80)) - 40;
      endcase
      if ($urandom_range(0, 1) == 0) dy = -dy;
      jit = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : 0;
      send_path(x0, y0, dx, dy, len, jit);
    end
  endtask

  task automatic run_random(int budget);
    int start;
    start = n_points;
    while (n_points - start < budget) random_path();
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (gestures.pending() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic cfg_access(input bit wr, input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_THRESHOLD, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_threshold(logic [THR_W-1:0] thr);
    logic [APB_DATA_W-1:0] rd;
    drain();
    cfg_access(1'b1, APB_DATA_W'(thr), rd);
    gestures.thr = thr;
    cfg_access(1'b0, '0, rd);
    if (rd !== APB_DATA_W'(thr))
      gestures.report_mismatch($sformatf("threshold reads 0x%0h, wrote 0x%0h", rd, thr));
  endtask

  initial begin
    logic [APB_DATA_W-1:0] rd;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    cfg_access(1'b0, '0, rd);
    if (rd !== APB_DATA_W'(THRESHOLD_RESET))
      gestures.report_mismatch($sformatf("threshold after reset 0x%0h", rd));

    // directed: single point, then 3-point lines for each direction and diagonal
    set_threshold(8'd128);
    send_path(COORD_MAX, COORD_MAX, 0, 0, 1, 0);
    send_path(COORD_MAX, 1000, -2048, 0, 3, 0);
    send_path(0, 3000, 2048, 0, 3, 0);
    send_path(1234, COORD_MAX, 0, -2048, 3, 0);
    send_path(3000, 0, 0, 2048, 3, 0);
    send_path(COORD_MAX, COORD_MAX, -100, -100, 3, 0);
    send_path(0, COORD_MAX, 100, -100, 3, 0);
    send_path(COORD_MAX, 0, -100, 100, 3, 0);
    send_path(0, 0, 100, 100, 3, 0);

    set_threshold(THRESHOLD_RESET);
    run_random(170);
    set_threshold('0);
    hold_armed = 1'b1;
    run_random(170);
    set_threshold('1);
    run_random(170);
    // one path just past the point-count bound
    set_threshold(THR_W'($urandom_range(0, 255)));
    send_path(0, $urandom_range(0, COORD_MAX), 3, 0, MAX_POINTS + 1, 2);
    run_random(100);
    set_threshold(THR_W'($urandom_range(0, 255)));
    run_random(170);
    drain();

    if (gestures.pending() != 0)
      gestures.report_mismatch($sformatf("%0d gestures never arrived", gestures.pending()));
    $display("covered %0d points in %0d paths, %0d gestures checked, %0d with overflow",
             n_points, n_paths, gestures.checked, gestures.ovf_paths);
    $display("thresholds 128, reset, 0, 255 and two random; one long receiver hold-off");
    if (gestures.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/swc_pkg.sv
rtl/swc_path_tracker.sv
rtl/swc_decide.sv
rtl/swipe_direction_classifier.sv
tb/sv/tb_swipe_direction_classifier.sv
